/* rtl/fcil_pkg.sv */
// fixed capacity list package: action and status codes, control state type
// no dependencies; imported by the list top level and its testbench
package fcil_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH      = 3'd0,
        ACT_POP       = 3'd1,
        ACT_READ      = 3'd2,
        ACT_OVERWRITE = 3'd3,
        ACT_FIND      = 3'd4,
        ACT_REMOVE    = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_EMPTY    = 3'd2,
        STAT_INDEX    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FIND,
        ST_REMOVE
    } t_state;

endpackage

/* rtl/fcil_if.sv */
// request and response channel interfaces of the fixed capacity list
// valid/ready handshake with payload; no dependencies
interface fcil_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [7:0]         position;
    logic signed [31:0] operand_value;

    modport source (output valid, output action, output position, output operand_value,
                    input ready);
    modport sink   (input valid, input action, input position, input operand_value,
                    output ready);
endinterface

interface fcil_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [8:0]         element_count;

    modport source (output valid, output status, output read_value, output found_position,
                    output element_count, input ready);
    modport sink   (input valid, input status, input read_value, input found_position,
                    input element_count, output ready);
endinterface

/* rtl/fcil_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies; used for the list element store
module fcil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fixed_capacity_int_list_top.sv */
// fixed capacity list of 32-bit signed words, top level
// depends on fcil_pkg, fcil_if (request and response interfaces) and fcil_ram
//
// Usage: one request on i_req (action, position, operand_value) gives exactly
// one response on o_rsp (status, read_value, found_position, element_count).
// Requests are taken one at a time; i_req.ready is high only while no request
// is in progress and the response register is empty or being taken.
// Path from request to response:
//   push, pop, overwrite, any refused request, unused codes: registered on acceptance
//   read: through ST_READ, waiting on the registered element store read
//   find: walks entries from index 0 to the first match, or through the count without one
//   remove: one element moved per cycle through the store; the last element needs no move
// The worst case is set by the one-entry-per-cycle walk
// over the single read port of the element store.
// A stalled receiver holds the response; no new request is taken until the
// response is accepted, and the next one may be taken in that same cycle.
// Reset empties the list and clears the response; the store itself is not
// cleared, only entries below the count are ever read.
module fixed_capacity_int_list_top #(
    parameter int CAPACITY = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcil_req_if.sink  i_req,
    fcil_rsp_if.source o_rsp
);
    import fcil_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = CW + 8;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic [31:0]        r_val, n_val;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic signed [31:0] r_rd, n_rd;
    logic [7:0]         r_fpos, n_fpos;
    logic [8:0]         r_ecount, n_ecount;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [31:0]        ram_rdata;

    logic               req_ready;
    logic               accept;
    logic               load_out;
    t_status            out_status;
    logic signed [31:0] out_rd;
    logic [7:0]         out_fpos;
    logic               pos_ok;
    logic               pos_last;
    logic [AW-1:0]      pos_addr;
    logic [CW-1:0]      idx_plus;

    fcil_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign req_ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept    = i_req.valid && req_ready;
    assign pos_ok    = PW'(i_req.position) < PW'(r_count);
    assign pos_last  = (PW'(i_req.position) + PW'(1)) == PW'(r_count);
    assign pos_addr  = AW'(i_req.position);
    assign idx_plus  = CW'(r_idx) + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_val       = r_val;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_rd        = r_rd;
        n_fpos      = r_fpos;
        n_ecount    = r_ecount;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;
        load_out    = 1'b0;
        out_status  = STAT_OK;
        out_rd      = '0;
        out_fpos    = '0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.action)
                        ACT_PUSH: begin
                            load_out = 1'b1;
                            if (r_count == CW'(CAPACITY)) begin
                                out_status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = i_req.operand_value;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        ACT_POP: begin
                            load_out = 1'b1;
                            if (r_count == '0) begin
                                out_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_READ: begin
                            if (!pos_ok) begin
                                load_out   = 1'b1;
                                out_status = STAT_INDEX;
                            end else begin
                                ram_raddr = pos_addr;
                                n_state   = ST_READ;
                            end
                        end
                        ACT_OVERWRITE: begin
                            load_out = 1'b1;
                            if (!pos_ok) begin
                                out_status = STAT_INDEX;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_addr;
                                ram_wdata = i_req.operand_value;
                            end
                        end
                        ACT_FIND: begin
                            n_val = i_req.operand_value;
                            if (r_count == '0) begin
                                load_out   = 1'b1;
                                out_status = STAT_NOTFOUND;
                            end else begin
                                ram_raddr = '0;
                                n_idx     = '0;
                                n_state   = ST_FIND;
                            end
                        end
                        ACT_REMOVE: begin
                            if (!pos_ok) begin
                                load_out   = 1'b1;
                                out_status = STAT_INDEX;
                            end else if (pos_last) begin
                                load_out = 1'b1;
                                n_count  = r_count - CW'(1);
                            end else begin
                                ram_raddr = pos_addr + AW'(1);
                                n_idx     = pos_addr + AW'(1);
                                n_state   = ST_REMOVE;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                load_out = 1'b1;
                out_rd   = ram_rdata;
                n_state  = ST_IDLE;
            end
            ST_FIND: begin
                if (ram_rdata == r_val) begin
                    load_out = 1'b1;
                    out_fpos = 8'(r_idx);
                    n_state  = ST_IDLE;
                end else if (idx_plus == r_count) begin
                    load_out   = 1'b1;
                    out_status = STAT_NOTFOUND;
                    n_state    = ST_IDLE;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            ST_REMOVE: begin
                // shift the element just read down by one
                ram_we    = 1'b1;
                ram_waddr = r_idx - AW'(1);
                ram_wdata = ram_rdata;
                if (idx_plus == r_count) begin
                    load_out = 1'b1;
                    n_count  = r_count - CW'(1);
                    n_state  = ST_IDLE;
                end else begin
                    ram_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_valid = 1'b1;
            n_status    = out_status;
            n_rd        = out_rd;
            n_fpos      = out_fpos;
            n_ecount    = 9'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_fpos   <= n_fpos;
        r_ecount <= n_ecount;
    end

    assign i_req.ready          = req_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.read_value     = r_rd;
    assign o_rsp.found_position = r_fpos;
    assign o_rsp.element_count  = r_ecount;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_busy_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (!r_out_valid && !i_req.ready))
        else $error("response or request ready while a request is in progress");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.action == ACT_PUSH) && (r_count != CW'(CAPACITY)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted push did not grow the list");

    a_done_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_READ) || (r_state == ST_REMOVE && idx_plus == r_count))
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished request gave no response");

endmodule

/* sim/tb_fixed_capacity_int_list_top.sv */
// testbench for fixed_capacity_int_list_top: directed table then random request mix,
// responses checked against an in-bench list predictor with random stalls on both sides
// depends on fcil_pkg, fcil_req_if / fcil_rsp_if and the list top level
module tb_fixed_capacity_int_list_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcil_pkg::*;

    localparam int CAPACITY      = 256;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = CAPACITY + 64;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  position;
        logic [31:0] operand;
    } t_list_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [7:0]  found_position;
        logic [8:0]  element_count;
    } t_list_result;

    typedef struct packed {
        t_list_request req;
        logic          typed;
        t_list_result  res;
    } t_dir_row;

    logic clk;
    logic rst_n;

    fcil_req_if req_if ();
    fcil_rsp_if rsp_if ();

    fixed_capacity_int_list_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    logic [31:0]  list_store [CAPACITY];
    int           list_count;
    t_list_result pending_results [$];
    t_dir_row     dir_rows [$];
    int           fail_count;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic t_list_result apply_list_request(input t_list_request r);
        t_list_result res;
        int k;
        res.status         = STAT_OK;
        res.read_value     = '0;
        res.found_position = '0;
        case (r.action)
            ACT_PUSH: begin
                if (list_count >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    list_store[list_count] = r.operand;
                    list_count++;
                end
            end
            ACT_POP: begin
                if (list_count == 0) res.status = STAT_EMPTY;
                else list_count--;
            end
            ACT_READ: begin
                if (int'(r.position) >= list_count) res.status = STAT_INDEX;
                else res.read_value = list_store[r.position];
            end
            ACT_OVERWRITE: begin
                if (int'(r.position) >= list_count) res.status = STAT_INDEX;
                else list_store[r.position] = r.operand;
            end
            ACT_FIND: begin
                res.status = STAT_NOTFOUND;
                for (k = 0; k < list_count; k++) begin
                    if (list_store[k] == r.operand) begin
                        res.status         = STAT_OK;
                        res.found_position = 8'(k);
                        break;
                    end
                end
            end
            ACT_REMOVE: begin
                if (int'(r.position) >= list_count) begin
                    res.status = STAT_INDEX;
                end else begin
                    for (k = int'(r.position); k + 1 < list_count; k++)
                        list_store[k] = list_store[k + 1];
                    list_count--;
                end
            end
            default: ;
        endcase
        res.element_count = 9'(list_count);
        return res;
    endfunction

    function automatic t_dir_row dir_row(input logic [2:0] action, input logic [7:0] position,
                                         input logic [31:0] operand, input logic typed,
                                         input t_status status, input logic [31:0] read_value,
                                         input logic [7:0] found_position,
                                         input logic [8:0] element_count);
        t_dir_row row;
        row.req.action         = action;
        row.req.position       = position;
        row.req.operand        = operand;
        row.typed              = typed;
        row.res.status         = status;
        row.res.read_value     = read_value;
        row.res.found_position = found_position;
        row.res.element_count  = element_count;
        return row;
    endfunction

    function automatic logic [31:0] draw_word(input bit for_find);
        int pick;
        pick = $urandom_range(0, 99);
        if (for_find && list_count > 0 && pick < 60)
            return list_store[$urandom_range(0, list_count - 1)];
        if (pick < 35) return 32'($urandom_range(0, 7));
        if (pick < 40) return 32'h7fff_ffff;
        if (pick < 45) return 32'h8000_0000;
        return $urandom();
    endfunction

    function automatic t_list_request draw_request(input int mode);
        t_list_request r;
        int pick;
        int cut [6];
        pick = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  cut = '{88, 90, 94, 96, 98, 99};
            MODE_DRAIN: cut = '{8, 50, 60, 65, 75, 98};
            default:    cut = '{25, 35, 55, 70, 85, 97};
        endcase
        if (pick < cut[0])      r.action = ACT_PUSH;
        else if (pick < cut[1]) r.action = ACT_POP;
        else if (pick < cut[2]) r.action = ACT_READ;
        else if (pick < cut[3]) r.action = ACT_OVERWRITE;
        else if (pick < cut[4]) r.action = ACT_FIND;
        else if (pick < cut[5]) r.action = ACT_REMOVE;
        else r.action = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;

        pick = $urandom_range(0, 99);
        if (pick < 80 && list_count > 0)
            r.position = 8'($urandom_range(0, list_count - 1));
        else if (pick < 88 && list_count < CAPACITY)
            r.position = 8'(list_count);
        else
            r.position = 8'($urandom_range(0, 255));

        r.operand = draw_word(r.action == ACT_FIND);
        return r;
    endfunction

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    // entered and left at a falling edge
    task automatic issue_request(input t_list_request r, input logic typed,
                                 input t_list_result typed_res, input int idx);
        int gap;
        t_list_result predicted;
        gap = draw_gap(((idx / 64) % 4) == 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.action        <= r.action;
        req_if.position      <= r.position;
        req_if.operand_value <= r.operand;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        predicted = apply_list_request(r);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic check_response(input int idx);
        t_list_result want;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("response %0d with no request pending: status %0d count %0d",
                                   idx, rsp_if.status, rsp_if.element_count));
            return;
        end
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status || rsp_if.read_value !== want.read_value ||
            rsp_if.found_position !== want.found_position ||
            rsp_if.element_count !== want.element_count) begin
            note_failure($sformatf(
                "response %0d exp st=%0d rd=%h fp=%0d cnt=%0d got st=%0d rd=%h fp=%0d cnt=%0d",
                idx, want.status, want.read_value, want.found_position, want.element_count,
                rsp_if.status, rsp_if.read_value, rsp_if.found_position,
                rsp_if.element_count));
        end
    endtask

    // response side with random back-pressure
    initial begin
        int gap;
        int n;
        rsp_if.ready = 1'b0;
        n = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = draw_gap(((n / 48) % 5) == 4);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
            check_response(n);
            n++;
            @(negedge clk);
        end
    end

    // ends the run when no handshake happens for too long
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
            else idle++;
            if (idle >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int i;
        int mode;
        t_list_result none;
        none = '0;
        fail_count = 0;
        list_count = 0;
        foreach (list_store[k]) list_store[k] = '0;

        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.action        = ACT_PUSH;
        req_if.position      = '0;
        req_if.operand_value = '0;

        // empty list cases
        dir_rows.push_back(dir_row(ACT_READ, 8'd0, 32'd0, 1'b1, STAT_INDEX, 32'd0, 8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_POP, 8'd0, 32'd0, 1'b1, STAT_EMPTY, 32'd0, 8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_FIND, 8'd0, 32'd0, 1'b1, STAT_NOTFOUND, 32'd0, 8'd0,
                                   9'd0));
        dir_rows.push_back(dir_row(ACT_REMOVE, 8'd0, 32'd0, 1'b1, STAT_INDEX, 32'd0, 8'd0,
                                   9'd0));
        dir_rows.push_back(dir_row(ACT_OVERWRITE, 8'd0, 32'hffff_ffff, 1'b1, STAT_INDEX, 32'd0,
                                   8'd0, 9'd0));
        // extreme words
        dir_rows.push_back(dir_row(ACT_PUSH, 8'd0, 32'h7fff_ffff, 1'b1, STAT_OK, 32'd0, 8'd0,
                                   9'd1));
        dir_rows.push_back(dir_row(ACT_PUSH, 8'hff, 32'h8000_0000, 1'b1, STAT_OK, 32'd0, 8'd0,
                                   9'd2));
        dir_rows.push_back(dir_row(ACT_PUSH, 8'd0, 32'hffff_ffff, 1'b1, STAT_OK, 32'd0, 8'd0,
                                   9'd3));
        dir_rows.push_back(dir_row(ACT_PUSH, 8'd0, 32'd0, 1'b1, STAT_OK, 32'd0, 8'd0, 9'd4));
        dir_rows.push_back(dir_row(ACT_READ, 8'd0, 32'd0, 1'b1, STAT_OK, 32'h7fff_ffff, 8'd0,
                                   9'd4));
        dir_rows.push_back(dir_row(ACT_READ, 8'd1, 32'd0, 1'b1, STAT_OK, 32'h8000_0000, 8'd0,
                                   9'd4));
        dir_rows.push_back(dir_row(ACT_READ, 8'd3, 32'd0, 1'b0, STAT_OK, 32'd0, 8'd0, 9'd0));
        // index at and far above count
        dir_rows.push_back(dir_row(ACT_READ, 8'd4, 32'd0, 1'b1, STAT_INDEX, 32'd0, 8'd0, 9'd4));
        dir_rows.push_back(dir_row(ACT_READ, 8'hff, 32'd0, 1'b1, STAT_INDEX, 32'd0, 8'd0,
                                   9'd4));
        dir_rows.push_back(dir_row(ACT_FIND, 8'd0, 32'hffff_ffff, 1'b0, STAT_OK, 32'd0, 8'd0,
                                   9'd0));
        dir_rows.push_back(dir_row(ACT_FIND, 8'd0, 32'h8000_0000, 1'b0, STAT_OK, 32'd0, 8'd0,
                                   9'd0));
        dir_rows.push_back(dir_row(ACT_FIND, 8'd0, 32'd12345, 1'b1, STAT_NOTFOUND, 32'd0, 8'd0,
                                   9'd4));
        dir_rows.push_back(dir_row(ACT_OVERWRITE, 8'd3, 32'h55aa_55aa, 1'b0, STAT_OK, 32'd0,
                                   8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_FIND, 8'd0, 32'h55aa_55aa, 1'b0, STAT_OK, 32'd0, 8'd0,
                                   9'd0));
        // unused codes leave the list alone
        dir_rows.push_back(dir_row(ACT_SPARE_LO, 8'd0, 32'd0, 1'b1, STAT_OK, 32'd0, 8'd0,
                                   9'd4));
        dir_rows.push_back(dir_row(ACT_SPARE_HI, 8'hff, 32'hffff_ffff, 1'b1, STAT_OK, 32'd0,
                                   8'd0, 9'd4));
        dir_rows.push_back(dir_row(ACT_REMOVE, 8'd1, 32'd0, 1'b0, STAT_OK, 32'd0, 8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_READ, 8'd1, 32'd0, 1'b0, STAT_OK, 32'd0, 8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_REMOVE, 8'd2, 32'd0, 1'b0, STAT_OK, 32'd0, 8'd0, 9'd0));
        dir_rows.push_back(dir_row(ACT_POP, 8'd0, 32'd0, 1'b0, STAT_OK, 32'd0, 8'd0, 9'd0));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < dir_rows.size(); i++)
            issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res, i);

        // fill to full, churn, drain toward empty, churn, fill again
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i < 320)       mode = MODE_FILL;
            else if (i < 520)  mode = MODE_MIXED;
            else if (i < 840)  mode = MODE_DRAIN;
            else if (i < 1040) mode = MODE_MIXED;
            else               mode = MODE_FILL;
            issue_request(draw_request(mode), 1'b0, none, i);
        end
        req_if.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* fixed_capacity_int_list_top.f */
rtl/fcil_pkg.sv
rtl/fcil_if.sv
rtl/fcil_ram.sv
rtl/fixed_capacity_int_list_top.sv
sim/tb_fixed_capacity_int_list_top.sv
